>>> src/sdfd_pkg.sv
// sdfd_pkg: shared types, constants and arithmetic helpers for the
// stereo decimating filtered delay. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sdfd_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam logic [16:0] WET_FULL = 17'd65536;

   // sequencer steps, shared by the top level and both lanes
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HIGH_MUL,
      ST_HIGH,
      ST_BAND_MUL,
      ST_BAND,
      ST_LOW_MUL,
      ST_LOW,
      ST_FB_MUL,
      ST_STORE,
      ST_MIX_MUL,
      ST_MIX
   } state_type;

   typedef enum logic [1:0] {
      FILT_LOW   = 2'd0,
      FILT_HIGH  = 2'd1,
      FILT_BAND  = 2'd2,
      FILT_NOTCH = 2'd3
   } filt_type;

   typedef enum logic [2:0] {
      CSR_WET_MIX     = 3'd0,
      CSR_DELAY_LEFT  = 3'd1,
      CSR_DELAY_RIGHT = 3'd2,
      CSR_HOLD_RATE   = 3'd3,
      CSR_QUANT_BITS  = 3'd4,
      CSR_SVF_COEFFS  = 3'd5,
      CSR_FB_GAINS    = 3'd6,
      CSR_MODE        = 3'd7
   } csr_index_type;

   // control group from the sequencer to each lane
   typedef struct packed {
      state_type   state;
      logic        start;
      logic        capture;
      logic        first;
      filt_type    filt;
      logic [4:0]  quant_bits;
      logic [15:0] g;
      logic [15:0] r;
      logic [16:0] wet;
   } lane_ctl_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] res;
      if (v > 64'sd2147483647)
         res = 32'sh7FFFFFFF;
      else if (v < -64'sd2147483648)
         res = 32'sh80000000;
      else
         res = v[31:0];
      return res;
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
      logic signed [23:0] res;
      if (v > 64'sd8388607)
         res = 24'sh7FFFFF;
      else if (v < -64'sd8388608)
         res = 24'sh800000;
      else
         res = v[23:0];
      return res;
   endfunction

   // bit reduction: clear low magnitude bits, keep the sign
   function automatic logic signed [23:0] crush(input logic signed [23:0] x,
                                                input logic [4:0] qb);
      logic [4:0]  qe;
      logic [4:0]  s;
      logic [23:0] mag;
      logic [23:0] mask;
      logic signed [23:0] res;
      qe = (qb == 5'd0) ? 5'd1 : qb;
      s = 5'd23 - qe;
      mag = x[23] ? 24'(-x) : 24'(x);
      mask = ~((24'd1 << s) - 24'd1);
      mag = mag & mask;
      if (qe >= 5'd23)
         res = x;
      else
         res = x[23] ? -$signed(mag) : $signed(mag);
      return res;
   endfunction

endpackage
`default_nettype wire

>>> src/sdfd_req_if.sv
// sdfd_req_if: request channel carrying one stereo input pair.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface sdfd_req_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] left_in;
   logic signed [23:0] right_in;
   modport source (output valid, left_in, right_in, input ready);
   modport sink (input valid, left_in, right_in, output ready);
endinterface
`default_nettype wire

>>> src/sdfd_rsp_if.sv
// sdfd_rsp_if: response channel carrying one processed stereo pair.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface sdfd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] left_out;
   logic signed [23:0] right_out;
   modport source (output valid, left_out, right_out, input ready);
   modport sink (input valid, left_out, right_out, output ready);
endinterface
`default_nettype wire

>>> src/sdfd_lane.sv
// sdfd_lane: one channel core: hold register, state-variable filter,
// bit reduction, feedback delay memory and dry/wet mix. Uses sdfd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sdfd_lane #(
   parameter int DELAY_DEPTH = 131072
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sdfd_pkg::lane_ctl_type        ctl,
   input  wire logic [$clog2(DELAY_DEPTH)-1:0] write_index,
   input  wire logic                          wrapped,
   input  wire logic signed [23:0]            sample_in,
   input  wire logic [16:0]                   delay_len,
   input  wire logic [15:0]                   gain,
   output logic signed [23:0]                 result
);
   import sdfd_pkg::*;

   localparam int AW = $clog2(DELAY_DEPTH);

   logic signed [23:0] delay_mem [DELAY_DEPTH];

   logic signed [23:0] dry_ff, held_ff, x_ff, rd_data_ff;
   logic signed [31:0] low_ff, band_ff, high_ff;
   logic signed [48:0] prod_ff;
   logic signed [42:0] pa_ff, pb_ff;
   logic               rd_valid_ff;

   logic [31:0]        d_wide;
   logic [AW-1:0]      d_clamp;
   logic [AW:0]        rd_sum;
   logic [AW-1:0]      rd_addr;
   logic signed [23:0] delayed;
   logic signed [31:0] y32;
   logic signed [23:0] y24;
   logic signed [23:0] x_next;

   // read address from the clamped delay length
   always_comb begin
      d_wide = {15'd0, delay_len};
      if (d_wide == 32'd0)
         d_clamp = AW'(1);
      else if (d_wide > 32'(DELAY_DEPTH - 1))
         d_clamp = AW'(DELAY_DEPTH - 1);
      else
         d_clamp = d_wide[AW-1:0];
      if (write_index >= d_clamp)
         rd_sum = {1'b0, write_index} - {1'b0, d_clamp};
      else
         rd_sum = {1'b0, write_index} + ((AW+1)'(DELAY_DEPTH) - {1'b0, d_clamp});
      rd_addr = rd_sum[AW-1:0];
   end

   // entries never written read as zero
   assign delayed = rd_valid_ff ? rd_data_ff : 24'sd0;

   // filter output select, saturation and, when first is clear, late bit reduction
   always_comb begin
      unique case (ctl.filt)
         FILT_LOW:   y32 = low_ff;
         FILT_HIGH:  y32 = high_ff;
         FILT_BAND:  y32 = band_ff;
         FILT_NOTCH: y32 = sat32(64'(low_ff) + 64'(high_ff));
         default:    y32 = low_ff;
      endcase
      y24 = sat24(64'(y32));
      x_next = ctl.first ? y24 : crush(y24, ctl.quant_bits);
   end

   // delay memory
   always_ff @(posedge clock) begin
      if (ctl.start)
         rd_data_ff <= delay_mem[rd_addr];
      if (ctl.state == ST_STORE)
         delay_mem[write_index] <= sat24(64'(x_ff) + (64'(prod_ff) >>> 16));
   end

   // step datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 24'sd0;
         low_ff <= 32'sd0;
         band_ff <= 32'sd0;
         high_ff <= 32'sd0;
      end else begin
         if (ctl.start) begin
            dry_ff <= sample_in;
            rd_valid_ff <= wrapped || (rd_addr < write_index);
            if (ctl.capture)
               held_ff <= ctl.first ? crush(sample_in, ctl.quant_bits) : sample_in;
         end
         unique case (ctl.state)
            ST_HIGH_MUL: prod_ff <= $signed({1'b0, ctl.r}) * band_ff;
            ST_HIGH: high_ff <= sat32(64'(held_ff) - 64'(low_ff) - (64'(prod_ff) >>> 11));
            ST_BAND_MUL: prod_ff <= $signed({1'b0, ctl.g}) * high_ff;
            ST_BAND: band_ff <= sat32(64'(band_ff) + (64'(prod_ff) >>> 16));
            ST_LOW_MUL: prod_ff <= $signed({1'b0, ctl.g}) * band_ff;
            ST_LOW: low_ff <= sat32(64'(low_ff) + (64'(prod_ff) >>> 16));
            ST_FB_MUL: begin
               x_ff <= x_next;
               prod_ff <= 49'(delayed) * 49'($signed({1'b0, gain}));
            end
            ST_MIX_MUL: begin
               pa_ff <= 43'(dry_ff) * 43'($signed({1'b0, WET_FULL - ctl.wet}));
               pb_ff <= 43'(delayed) * 43'($signed({1'b0, ctl.wet}));
            end
            default: ;
         endcase
      end
   end

   assign result = sat24((64'(pa_ff) + 64'(pb_ff)) >>> 16);

endmodule
`default_nettype wire

>>> src/stereo_decimating_filtered_delay.sv
// stereo_decimating_filtered_delay: top level with configuration registers,
// hold counter, step sequencer, two sdfd_lane instances and the output merge.
// The response is registered when the sequencer leaves its mix step, which can
// stall until the output is free; a new request is taken only in the idle step.
// Reset (synchronous) restores register defaults, zeroes the filter and hold
// state; the delay memories need no clearing pass, unwritten entries read zero.
`timescale 1ns / 1ps
`default_nettype none
module stereo_decimating_filtered_delay #(
   parameter int DELAY_DEPTH = 131072
) (
   input  wire logic        clock,
   input  wire logic        reset,
   sdfd_req_if.sink         req,
   sdfd_rsp_if.source       rsp,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_write_data
);
   import sdfd_pkg::*;

   localparam int AW = $clog2(DELAY_DEPTH);

   logic [16:0] wet_mix_ff, delay_left_ff, delay_right_ff;
   logic [6:0]  hold_rate_ff, hold_count_ff;
   logic [4:0]  quant_bits_ff;
   logic [31:0] svf_coeffs_ff, fb_gains_ff;
   logic [2:0]  mode_ff;
   logic [AW-1:0] write_index_ff;
   logic        wrapped_ff;
   state_type   state_ff, state_in;
   logic        rsp_valid_ff;
   logic signed [23:0] left_out_ff, right_out_ff;

   logic        start;
   logic        can_out;
   logic [6:0]  rate, count_next;
   logic        capture;
   lane_ctl_type ctl;
   logic signed [23:0] left_res, right_res;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wet_mix_ff <= 17'd0;
         delay_left_ff <= 17'd48000;
         delay_right_ff <= 17'd48000;
         hold_rate_ff <= 7'd1;
         quant_bits_ff <= 5'd24;
         svf_coeffs_ff <= 32'd0;
         fb_gains_ff <= 32'd0;
         mode_ff <= 3'd0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_WET_MIX:     wet_mix_ff <= csr_write_data[16:0];
            CSR_DELAY_LEFT:  delay_left_ff <= csr_write_data[16:0];
            CSR_DELAY_RIGHT: delay_right_ff <= csr_write_data[16:0];
            CSR_HOLD_RATE:   hold_rate_ff <= csr_write_data[6:0];
            CSR_QUANT_BITS:  quant_bits_ff <= csr_write_data[4:0];
            CSR_SVF_COEFFS:  svf_coeffs_ff <= csr_write_data;
            CSR_FB_GAINS:    fb_gains_ff <= csr_write_data;
            CSR_MODE:        mode_ff <= csr_write_data[2:0];
            default: ;
         endcase
      end
   end

   // hold counter decision
   always_comb begin
      rate = (hold_rate_ff == 7'd0) ? 7'd1 : hold_rate_ff;
      count_next = hold_count_ff + 7'd1;
      capture = count_next >= rate;
   end

   assign can_out = !rsp_valid_ff || rsp.ready;

   // next state
   always_comb begin
      unique case (state_ff)
         ST_IDLE:     state_in = req.valid ? ST_HIGH_MUL : ST_IDLE;
         ST_HIGH_MUL: state_in = ST_HIGH;
         ST_HIGH:     state_in = ST_BAND_MUL;
         ST_BAND_MUL: state_in = ST_BAND;
         ST_BAND:     state_in = ST_LOW_MUL;
         ST_LOW_MUL:  state_in = ST_LOW;
         ST_LOW:      state_in = ST_FB_MUL;
         ST_FB_MUL:   state_in = ST_STORE;
         ST_STORE:    state_in = ST_MIX_MUL;
         ST_MIX_MUL:  state_in = ST_MIX;
         ST_MIX:      state_in = can_out ? ST_IDLE : ST_MIX;
         default:     state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req.ready = (state_ff == ST_IDLE);
      start = req.valid && (state_ff == ST_IDLE);
      ctl.state = state_ff;
      ctl.start = start;
      ctl.capture = capture;
      ctl.first = mode_ff[2];
      ctl.filt = filt_type'(mode_ff[1:0]);
      ctl.quant_bits = quant_bits_ff;
      ctl.g = svf_coeffs_ff[15:0];
      ctl.r = svf_coeffs_ff[31:16];
      ctl.wet = (wet_mix_ff > WET_FULL) ? WET_FULL : wet_mix_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hold_count_ff <= 7'd0;
         write_index_ff <= '0;
         wrapped_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (start)
            hold_count_ff <= capture ? 7'd0 : count_next;
         if (state_ff == ST_STORE) begin
            if (write_index_ff == AW'(DELAY_DEPTH - 1)) begin
               write_index_ff <= '0;
               wrapped_ff <= 1'b1;
            end else begin
               write_index_ff <= write_index_ff + AW'(1);
            end
         end
         if (state_ff == ST_MIX && can_out)
            rsp_valid_ff <= 1'b1;
         else if (rsp.ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   // merge lane results into the response register
   always_ff @(posedge clock) begin
      if (state_ff == ST_MIX && can_out) begin
         left_out_ff <= left_res;
         right_out_ff <= right_res;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.left_out = left_out_ff;
   assign rsp.right_out = right_out_ff;

   sdfd_lane #(.DELAY_DEPTH(DELAY_DEPTH)) u_lane_left (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .write_index (write_index_ff),
      .wrapped     (wrapped_ff),
      .sample_in   (req.left_in),
      .delay_len   (delay_left_ff),
      .gain        (fb_gains_ff[15:0]),
      .result      (left_res)
   );

   sdfd_lane #(.DELAY_DEPTH(DELAY_DEPTH)) u_lane_right (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .write_index (write_index_ff),
      .wrapped     (wrapped_ff),
      .sample_in   (req.right_in),
      .delay_len   (delay_right_ff),
      .gain        (fb_gains_ff[31:16]),
      .result      (right_res)
   );

endmodule
`default_nettype wire
